/* sv/sexpr_token_lexer_top_defines.svh */
// Assertion macros for the S-expression lexer.
`ifndef SEXPR_TOKEN_LEXER_TOP_DEFINES_SVH
`define SEXPR_TOKEN_LEXER_TOP_DEFINES_SVH
`ifndef SYNTH
`define SXL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sexpr lexer check failed");
`define SXL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sexpr lexer check failed in or out of reset");
`else
`define SXL_ASSERT(lbl, prop)
`define SXL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* sv/sxl_pkg.sv */
// Shared types, character codes and sizes for the S-expression lexer.
package sxl_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int TOKEN_POS_W = 16;
  localparam int TOKEN_LEN_W = 16;
  localparam logic [TOKEN_LEN_W-1:0] LEN_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    KIND_OPEN    = 3'd0,
    KIND_CLOSE   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_SYMBOL  = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [TOKEN_POS_W-1:0] start;
    logic [TOKEN_LEN_W-1:0] length;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room2;
  } fifo_status_t;

  function automatic token_t make_token(kind_t kind, logic [TOKEN_POS_W-1:0] start,
                                        logic [TOKEN_LEN_W-1:0] length, logic last);
    token_t t;
    t.kind = kind;
    t.start = start;
    t.length = length;
    t.last = last;
    return t;
  endfunction

endpackage

/* sv/sxl_if.sv */
// Valid/ready channels for source characters and lexer tokens.
interface sxl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface sxl_token_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        token_kind;
  logic [sxl_pkg::TOKEN_POS_W-1:0]   token_start;
  logic [sxl_pkg::TOKEN_LEN_W-1:0]   token_length;
  logic                              last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input last_of_run, output ready);
endinterface

/* sv/sxl_step.sv */
// Lexer state and per-character token logic.
module sxl_step #(
  parameter int POSITION_BITS = sxl_pkg::POSITION_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_valid,
  input  logic [7:0]      char_code,
  input  logic            end_of_input,
  output logic [1:0]      tok_count,
  output sxl_pkg::token_t tok0,
  output sxl_pkg::token_t tok1
);

  logic [POSITION_BITS-1:0]         char_position, char_position_next;
  logic                             in_string, in_string_next;
  logic                             token_open, token_open_next;
  logic [sxl_pkg::TOKEN_POS_W-1:0]  open_start, open_start_next;
  logic [sxl_pkg::TOKEN_LEN_W-1:0]  open_length, open_length_next;
  logic                             number_ok, number_ok_next;
  logic                             dot_seen, dot_seen_next;
  logic                             symbol_ok, symbol_ok_next;

  logic                             is_digit, is_blank, is_paren, is_quote;
  logic                             is_dot, is_minus, first;
  logic                             nok_base, dot_base;
  logic [sxl_pkg::TOKEN_LEN_W-1:0]  len_inc;
  logic [sxl_pkg::TOKEN_POS_W-1:0]  pos_start;
  sxl_pkg::kind_t                   flush_kind, paren_kind;
  logic [1:0]                       count_raw;

  assign is_digit = (char_code >= sxl_pkg::CH_ZERO) && (char_code <= sxl_pkg::CH_NINE);
  assign is_blank = (char_code == sxl_pkg::CH_SPACE) || (char_code == sxl_pkg::CH_TAB) ||
                    (char_code == sxl_pkg::CH_NEWLINE);
  assign is_paren = (char_code == sxl_pkg::CH_LPAREN) || (char_code == sxl_pkg::CH_RPAREN);
  assign is_quote = char_code == sxl_pkg::CH_QUOTE;
  assign is_dot = char_code == sxl_pkg::CH_DOT;
  assign is_minus = char_code == sxl_pkg::CH_MINUS;
  assign first = !token_open;
  assign nok_base = first ? 1'b1 : number_ok;
  assign dot_base = first ? 1'b0 : dot_seen;
  assign len_inc = (open_length == sxl_pkg::LEN_MAX) ? open_length : open_length + 1'b1;
  assign pos_start = sxl_pkg::TOKEN_POS_W'(char_position);
  assign paren_kind = (char_code == sxl_pkg::CH_LPAREN) ? sxl_pkg::KIND_OPEN
                                                        : sxl_pkg::KIND_CLOSE;
  assign flush_kind = in_string ? sxl_pkg::KIND_UNKNOWN :
                      number_ok ? sxl_pkg::KIND_NUMBER :
                      symbol_ok ? sxl_pkg::KIND_SYMBOL : sxl_pkg::KIND_UNKNOWN;
  assign tok_count = step_valid ? count_raw : 2'd0;

  always_comb begin
    char_position_next = char_position + 1'b1;
    in_string_next = in_string;
    token_open_next = token_open;
    open_start_next = open_start;
    open_length_next = open_length;
    number_ok_next = number_ok;
    dot_seen_next = dot_seen;
    symbol_ok_next = symbol_ok;
    count_raw = 2'd0;
    tok0 = sxl_pkg::make_token(flush_kind, open_start, open_length, 1'b1);
    tok1 = sxl_pkg::make_token(paren_kind, pos_start, sxl_pkg::TOKEN_LEN_W'(1), 1'b1);

    if (end_of_input || (in_string && is_quote) || (!in_string && (is_blank || is_paren))) begin
      in_string_next = 1'b0;
      token_open_next = 1'b0;
      open_start_next = '0;
      open_length_next = '0;
      number_ok_next = 1'b1;
      dot_seen_next = 1'b0;
      symbol_ok_next = 1'b1;
    end

    if (end_of_input) begin
      char_position_next = '0;
      count_raw = token_open ? 2'd1 : 2'd0;
    end else if (in_string) begin
      if (is_quote) begin
        tok0 = sxl_pkg::make_token(sxl_pkg::KIND_STRING, open_start, len_inc, 1'b1);
        count_raw = 2'd1;
      end else begin
        open_length_next = len_inc;
      end
    end else if (is_blank) begin
      count_raw = token_open ? 2'd1 : 2'd0;
    end else if (is_paren) begin
      if (token_open) begin
        tok0.last = 1'b0;
        count_raw = 2'd2;
      end else begin
        tok0 = tok1;
        count_raw = 2'd1;
      end
    end else if (is_quote) begin
      count_raw = token_open ? 2'd1 : 2'd0;
      token_open_next = 1'b1;
      in_string_next = 1'b1;
      open_start_next = pos_start;
      open_length_next = sxl_pkg::TOKEN_LEN_W'(1);
      number_ok_next = 1'b1;
      dot_seen_next = 1'b0;
      symbol_ok_next = 1'b1;
    end else begin
      token_open_next = 1'b1;
      number_ok_next = nok_base;
      dot_seen_next = dot_base;
      if (first) begin
        open_start_next = pos_start;
        open_length_next = sxl_pkg::TOKEN_LEN_W'(1);
        symbol_ok_next = !is_digit;
      end else begin
        open_length_next = len_inc;
      end
      if (!is_digit) begin
        if (is_dot) begin
          if (dot_base) begin
            number_ok_next = 1'b0;
          end
          dot_seen_next = 1'b1;
        end else if (!(is_minus && first)) begin
          number_ok_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      in_string <= 1'b0;
      token_open <= 1'b0;
      open_start <= '0;
      open_length <= '0;
      number_ok <= 1'b1;
      dot_seen <= 1'b0;
      symbol_ok <= 1'b1;
    end else if (step_valid) begin
      char_position <= char_position_next;
      in_string <= in_string_next;
      token_open <= token_open_next;
      open_start <= open_start_next;
      open_length <= open_length_next;
      number_ok <= number_ok_next;
      dot_seen <= dot_seen_next;
      symbol_ok <= symbol_ok_next;
    end
  end

endmodule

/* sv/sxl_tok_fifo.sv */
// Token queue: takes up to two tokens a cycle, hands out one.
module sxl_tok_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_count,
  input  sxl_pkg::token_t       push0,
  input  sxl_pkg::token_t       push1,
  input  logic                  pop,
  output sxl_pkg::token_t       head,
  output sxl_pkg::fifo_status_t status
);

  sxl_pkg::token_t                 entries [sxl_pkg::FIFO_DEPTH];
  logic [sxl_pkg::FIFO_PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [sxl_pkg::FIFO_PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [sxl_pkg::FIFO_CNT_W-1:0]  count, count_next;

  assign wr_ptr_next = wr_ptr + sxl_pkg::FIFO_PTR_W'(push_count);
  assign rd_ptr_next = rd_ptr + sxl_pkg::FIFO_PTR_W'(pop);
  assign count_next = count + sxl_pkg::FIFO_CNT_W'(push_count) - sxl_pkg::FIFO_CNT_W'(pop);

  assign head = entries[rd_ptr];
  assign status.count = count;
  assign status.room2 = count <= sxl_pkg::FIFO_CNT_W'(sxl_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push1;
    end
  end

endmodule

/* sv/sexpr_token_lexer_top.sv */
// Top level of the S-expression lexer: input register, token logic, token queue.
// A character waits in the input register until the queue has room for two tokens;
// its tokens then go into the queue. Throughput: one character per cycle while
// the queue has room; a beat's tokens leave in turn by the single read port.
// Reset (rst, synchronous): empties both stages and the queue, position back to zero.
`include "sexpr_token_lexer_top_defines.svh"
module sexpr_token_lexer_top #(
  parameter int POSITION_BITS = sxl_pkg::POSITION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  sxl_char_if.sink    char_in,
  sxl_token_if.source token_out
);

  logic                  in_valid_q;
  logic [7:0]            char_q;
  logic                  eoi_q;
  logic                  fire;
  logic                  pop;
  logic [1:0]            tok_count;
  sxl_pkg::token_t       tok0, tok1, head;
  sxl_pkg::fifo_status_t status;

  assign fire = in_valid_q && status.room2;
  assign char_in.ready = !in_valid_q || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (char_in.ready) begin
      in_valid_q <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      char_q <= char_in.char_code;
      eoi_q <= char_in.end_of_input;
    end
  end

  sxl_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .step_valid  (fire),
    .char_code   (char_q),
    .end_of_input(eoi_q),
    .tok_count   (tok_count),
    .tok0        (tok0),
    .tok1        (tok1)
  );

  sxl_tok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(tok_count),
    .push0     (tok0),
    .push1     (tok1),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  assign pop = token_out.valid && token_out.ready;
  assign token_out.valid = status.count != '0;
  assign token_out.token_kind = head.kind;
  assign token_out.token_start = head.start;
  assign token_out.token_length = head.length;
  assign token_out.last_of_run = head.last;

  `SXL_ASSERT_ALWAYS(a_count_bound, rst || status.count <= sxl_pkg::FIFO_CNT_W'(sxl_pkg::FIFO_DEPTH))
  `SXL_ASSERT(a_push_has_room, tok_count != 2'd0 |-> status.room2)
  `SXL_ASSERT(a_hold_stalled, in_valid_q && !fire |=> in_valid_q && $stable(char_q) && $stable(eoi_q))
  `SXL_ASSERT(a_last_mark, tok_count == 2'd2 |-> !tok0.last && tok1.last)

endmodule
